// ----- src/iprtl_pkg.sv -----
// ============================================================================
// iprtl_pkg : shared types and constants for the IP range table lookup
// Field widths, command and register codes, table entry and status types.
// ============================================================================
package iprtl_pkg;

    localparam int DEFAULT_TABLE_ENTRIES = 4096;

    localparam int CFG_W  = 13;   // first_entry / end_entry
    localparam int EIDX_W = 12;   // entry_index / found_index ports
    localparam int IP_W   = 32;
    localparam int OFF_W  = 24;

    // command codes
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // configuration register indexes
    localparam logic CFG_IDX_FIRST_ENTRY = 1'b0;
    localparam logic CFG_IDX_END_ENTRY   = 1'b1;

    typedef struct packed {
        logic [IP_W-1:0]  start;
        logic [OFF_W-1:0] offset;
    } entry_t;

    typedef struct packed {
        logic busy;
        logic done;
    } search_status_t;

endpackage

// ----- src/ip_range_table_lookup.sv -----
// ============================================================================
// ip_range_table_lookup : IPv4 range table with binary search lookup
// Stores range start addresses with record offsets; finds the range of a key.
// ============================================================================
// Usage: a transaction is taken on a rising edge with start high and busy low.
// A write transaction (cmd = write) stores one entry and gives no result;
// indexes at or above TABLE_ENTRIES are dropped. A lookup
// searches entries first_entry .. end_entry-1, which must be written and
// sorted ascending. busy stays high while the search runs, one table read per
// level, so a lookup over a span of S entries needs about ceil(log2 S) levels
// (at least one), followed by a result state. The result sits on
// found_index/found_offset for exactly one cycle, marked by done, and
// cannot be held off, so capture it then. A new transaction may already be
// started in the done cycle. The single read port of the table sets the
// rate. The table has no reset and needs no clearing pass; a key below
// every entry returns first_entry. Change the configuration registers only
// while no lookup is in flight.
// ============================================================================
module ip_range_table_lookup
    import iprtl_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES
)
(
    input  logic              clk,
    input  logic              rst_n,

    // configuration write port
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,

    // command channel
    input  logic              start,
    output logic              busy,
    input  logic              cmd,
    input  logic [EIDX_W-1:0] entry_index,
    input  logic [IP_W-1:0]   ip_value,
    input  logic [OFF_W-1:0]  record_offset,

    // result channel
    output logic              done,
    output logic [EIDX_W-1:0] found_index,
    output logic [OFF_W-1:0]  found_offset
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int PW    = ((IDX_W + 1) > CFG_W) ? (IDX_W + 1) : CFG_W;
    localparam logic [PW-1:0] ENTRIES_P = PW'(TABLE_ENTRIES);

    logic [CFG_W-1:0]  first_entry_reg;
    logic [CFG_W-1:0]  end_entry_reg;

    search_status_t    status;
    logic              accept;
    logic              wr_en;
    logic              go;
    logic [PW-1:0]     wr_index_p;
    logic [IDX_W-1:0]  rd_addr;
    entry_t            wr_entry;
    entry_t            rd_entry;

    // configuration registers; the user must write them only while idle, the block itself does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_entry_reg <= '0;
            end_entry_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IDX_FIRST_ENTRY: first_entry_reg <= cfg_data;
                CFG_IDX_END_ENTRY:   end_entry_reg   <= cfg_data;
                default:             ;
            endcase
        end
    end

    // transaction decode
    assign accept     = start && !status.busy;
    assign wr_index_p = PW'(entry_index);
    assign wr_en      = accept && (cmd == CMD_WRITE) && (wr_index_p < ENTRIES_P);
    assign go         = accept && (cmd == CMD_LOOKUP);

    assign wr_entry.start  = ip_value;
    assign wr_entry.offset = record_offset;

    // table: both fields share one word, so the final probe address
    // also returns the record offset in the following cycle
    iprtl_table #(
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_index_p[IDX_W-1:0]),
        .wdata (wr_entry),
        .raddr (rd_addr),
        .rdata (rd_entry)
    );

    // binary search sequencer
    iprtl_search #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_search (
        .clk         (clk),
        .rst_n       (rst_n),
        .go          (go),
        .key         (ip_value),
        .first_entry (first_entry_reg),
        .end_entry   (end_entry_reg),
        .rd_start    (rd_entry.start),
        .rd_addr     (rd_addr),
        .status      (status),
        .found_index (found_index)
    );

    assign busy         = status.busy;
    assign done         = status.done;
    assign found_offset = rd_entry.offset;

endmodule

// ----- src/iprtl_table.sv -----
// ============================================================================
// iprtl_table : range table storage
// One write port, one read port with registered read data.
// ============================================================================
module iprtl_table
    import iprtl_pkg::*;
#(
    parameter int DEPTH = DEFAULT_TABLE_ENTRIES,
    localparam int ADDR_W = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  entry_t            wdata,
    input  logic [ADDR_W-1:0] raddr,
    output entry_t            rdata
);

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/iprtl_search.sv -----
// ============================================================================
// iprtl_search : binary search sequencer
// Key compare and halving adder reused per level; a second adder seeds mid.
// ============================================================================
module iprtl_search
    import iprtl_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES,
    localparam int IDX_W = $clog2(TABLE_ENTRIES)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  logic [IP_W-1:0]   key,
    input  logic [CFG_W-1:0]  first_entry,
    input  logic [CFG_W-1:0]  end_entry,
    input  logic [IP_W-1:0]   rd_start,
    output logic [IDX_W-1:0]  rd_addr,
    output search_status_t    status,
    output logic [EIDX_W-1:0] found_index
);

    localparam int RW = IDX_W + 1;
    localparam int PW = (RW > CFG_W) ? RW : CFG_W;
    localparam logic [PW-1:0] LAST_P    = PW'(TABLE_ENTRIES - 1);
    localparam logic [PW-1:0] ENTRIES_P = PW'(TABLE_ENTRIES);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_OUT    = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  left_reg, left_next;
    logic [RW-1:0]     right_reg, right_next;
    logic [IDX_W-1:0]  mid_reg, mid_next;
    logic [IP_W-1:0]   key_reg, key_next;

    logic [PW-1:0]     first_p, end_p, left_init_p, right_init_p, mid_p;
    logic [IDX_W-1:0]  left_init, mid_init;
    logic [RW-1:0]     right_init;
    logic              key_lt;
    logic [IDX_W-1:0]  left_step, mid_step;
    logic [RW-1:0]     right_step;
    logic              more;

    // mid = left + (right - left) / 2, right >= left always
    function automatic logic [IDX_W-1:0] half_mid(input logic [IDX_W-1:0] l,
                                                  input logic [RW-1:0] r);
        logic [RW-1:0] sum;
        begin
            sum = RW'(l) + ((r - RW'(l)) >> 1);
            return sum[IDX_W-1:0];
        end
    endfunction

    // clamp configured bounds into the table
    always_comb
    begin
        first_p      = PW'(first_entry);
        end_p        = PW'(end_entry);
        left_init_p  = (first_p > LAST_P) ? LAST_P : first_p;
        right_init_p = (end_p > ENTRIES_P) ? ENTRIES_P : end_p;
        if (right_init_p < left_init_p)
        begin
            right_init_p = left_init_p;
        end
        left_init  = left_init_p[IDX_W-1:0];
        right_init = right_init_p[RW-1:0];
        mid_init   = half_mid(left_init, right_init);
    end

    // one search level
    always_comb
    begin
        key_lt     = key_reg < rd_start;
        left_step  = key_lt ? left_reg : mid_reg;
        right_step = key_lt ? RW'(mid_reg) : right_reg;
        mid_step   = half_mid(left_step, right_step);
        more       = mid_step > left_step;
    end

    always_comb
    begin
        state_next = state_reg;
        left_next  = left_reg;
        right_next = right_reg;
        mid_next   = mid_reg;
        key_next   = key_reg;
        rd_addr    = mid_init;
        unique case (state_reg) inside
            S_IDLE, S_OUT:
            begin
                state_next = S_IDLE;
                if (go)
                begin
                    state_next = S_SEARCH;
                    left_next  = left_init;
                    right_next = right_init;
                    mid_next   = mid_init;
                    key_next   = key;
                end
            end
            S_SEARCH:
            begin
                rd_addr    = mid_step;
                left_next  = left_step;
                right_next = right_step;
                mid_next   = mid_step;
                state_next = more ? S_SEARCH : S_OUT;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg  <= left_next;
        right_reg <= right_next;
        mid_reg   <= mid_next;
        key_reg   <= key_next;
    end

    assign mid_p        = PW'(mid_reg);
    assign found_index  = mid_p[EIDX_W-1:0];
    assign status.busy  = (state_reg == S_SEARCH);
    assign status.done  = (state_reg == S_OUT);

    // bounds never cross while searching
    a_bounds_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |-> (RW'(left_reg) <= right_reg))
        else $error("search bounds crossed");

    // the interval shrinks on every level
    a_interval_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) ##1 (state_reg == S_SEARCH) |->
        ((right_reg - RW'(left_reg)) < $past(right_reg - RW'(left_reg))))
        else $error("search interval did not shrink");

    // last level is followed by the result strobe
    a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) && !more |=> status.done)
        else $error("missing result after last level");

    // a lookup start always enters the search
    a_go_searches: assert property (@(posedge clk) disable iff (!rst_n)
        go |=> status.busy)
        else $error("lookup not started");

endmodule

// ----- tb/tb_top.sv -----
// ============================================================================
// tb_top : testbench for the IP range table lookup
// Loads windows of the range table, moves the search bounds between phases and
// checks every lookup result against a typed-in answer or a bit-true predictor.
// ============================================================================
module tb_top
    import iprtl_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TBL         = DEFAULT_TABLE_ENTRIES;
    localparam int SETTLE      = 16;     // a little over the deepest search
    localparam int QUIET_LIMIT = 2000;   // cycles with no transaction at all
    localparam int ITEM_TARGET = 1100;

    // ------------------------------------------------------------------------
    // DUT signals, all inputs driven from time zero
    // ------------------------------------------------------------------------
    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic              cfg_index;
    logic [CFG_W-1:0]  cfg_data;
    logic              start;
    logic              busy;
    logic              cmd;
    logic [EIDX_W-1:0] entry_index;
    logic [IP_W-1:0]   ip_value;
    logic [OFF_W-1:0]  record_offset;
    logic              done;
    logic [EIDX_W-1:0] found_index;
    logic [OFF_W-1:0]  found_offset;

    ip_range_table_lookup dut (.*);

    // one lookup answer: entry index and its record offset
    typedef struct {
        bit [EIDX_W-1:0] idx;
        bit [OFF_W-1:0]  off;
    } hit_t;

    // directed stimulus row: either a register write or a transaction,
    // with the answer typed in where it is obvious
    typedef struct {
        bit              is_reg;
        logic            reg_sel;
        bit [CFG_W-1:0]  reg_val;
        logic            op;
        bit [EIDX_W-1:0] slot;
        bit [IP_W-1:0]   ip;
        bit [OFF_W-1:0]  off;
        bit              typed;
        hit_t            want;
    } stim_row_t;

    // ------------------------------------------------------------------------
    // Predictor state: its own copy of the table and of the two bounds
    // ------------------------------------------------------------------------
    bit [IP_W-1:0]  range_start [TBL];
    bit [OFF_W-1:0] range_off   [TBL];
    bit [CFG_W-1:0] first_reg;
    bit [CFG_W-1:0] end_reg;

    hit_t      pending_hits[$];     // answers still owed by the block
    stim_row_t directed_rows[$];

    int errors;
    int quiet;
    int n_writes;
    int n_lookups;
    int n_checked;
    int n_reg_writes;

    // Binary search exactly as the block walks it: clamp both bounds to the
    // table, collapse an empty or inverted span onto the first entry, then
    // halve until the midpoint stops moving.
    function automatic hit_t search_table(input bit [IP_W-1:0] key);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        bit          going;
        hit_t        h;
        lo = 32'(first_reg);
        if (lo > TBL - 1)
            lo = TBL - 1;
        hi = 32'(end_reg);
        if (hi > TBL)
            hi = TBL;
        if (hi < lo)
            hi = lo;
        mid   = lo + (hi - lo) / 2;
        going = 1'b1;
        while (going)
        begin
            if (key < range_start[mid])
                hi = mid;
            else
                lo = mid;
            mid   = lo + (hi - lo) / 2;
            going = (lo < mid);
        end
        h.idx = mid[EIDX_W-1:0];
        h.off = range_off[mid];
        return h;
    endfunction

    // ------------------------------------------------------------------------
    // Directed table helpers
    // ------------------------------------------------------------------------
    function automatic stim_row_t reg_row(input logic sel, input bit [CFG_W-1:0] val);
        stim_row_t r;
        r.is_reg  = 1'b1;
        r.reg_sel = sel;
        r.reg_val = val;
        return r;
    endfunction

    function automatic stim_row_t wr_row(input bit [EIDX_W-1:0] slot,
                                         input bit [IP_W-1:0] ip,
                                         input bit [OFF_W-1:0] off);
        stim_row_t r;
        r.is_reg = 1'b0;
        r.op     = CMD_WRITE;
        r.slot   = slot;
        r.ip     = ip;
        r.off    = off;
        r.typed  = 1'b0;
        return r;
    endfunction

    function automatic stim_row_t lk_row(input bit [IP_W-1:0] key, input bit typed,
                                         input bit [EIDX_W-1:0] idx,
                                         input bit [OFF_W-1:0] off);
        stim_row_t r;
        r.is_reg   = 1'b0;
        r.op       = CMD_LOOKUP;
        r.slot     = EIDX_W'($urandom);   // ignored by a lookup, so let it wander
        r.ip       = key;
        r.off      = OFF_W'($urandom);
        r.typed    = typed;
        r.want.idx = idx;
        r.want.off = off;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Clock generation
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Driver tasks. Everything changes on the falling edge; busy is looked at
    // on the rising edge, where it still holds its pre-edge value.
    // ------------------------------------------------------------------------

    // Register write, only ever called once the block has gone quiet.
    task automatic write_reg(input logic sel, input bit [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = sel;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        if (sel == CFG_IDX_FIRST_ENTRY)
            first_reg = val;
        else
            end_reg = val;
        n_reg_writes++;
    endtask

    // Drop start and wait until every answer is in and busy is low, then give
    // any write still in progress time to land before touching a register.
    task automatic settle();
        @(negedge clk);
        start = 1'b0;
        while (pending_hits.size() != 0 || busy)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Gap between transactions: mostly none or short, now and then long.
    task automatic hold_off(input bit quick);
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (quick || pick < 55)
            n = 0;
        else if (pick < 90)
            n = $urandom_range(1, 3);
        else
            n = $urandom_range(6, 50);
        if (n > 0)
        begin
            @(negedge clk);
            start         = 1'b0;
            cmd           = 1'($urandom);   // junk on the bus while start is low
            ip_value      = $urandom;
            record_offset = OFF_W'($urandom);
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // One transaction. The predictor runs at the edge that accepts it, so the
    // table and bounds it sees are those the block sees.
    task automatic issue(input logic op, input bit [EIDX_W-1:0] slot,
                         input bit [IP_W-1:0] ip, input bit [OFF_W-1:0] off,
                         input bit typed, input hit_t want);
        @(negedge clk);
        start         = 1'b1;
        cmd           = op;
        entry_index   = slot;
        ip_value      = ip;
        record_offset = off;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (op == CMD_WRITE)
        begin
            range_start[slot] = ip;
            range_off[slot]   = off;
            n_writes++;
        end
        else
        begin
            pending_hits.push_back(typed ? want : search_table(ip));
            n_lookups++;
        end
    endtask

    // ------------------------------------------------------------------------
    // One random phase: load a window with fresh entries, pick bounds for it
    // (sometimes beyond the table, inverted or empty) and fire lookups at it.
    // ------------------------------------------------------------------------
    task automatic run_phase();
        int             pick;
        int             span;
        int             base_slot;
        int             mode;
        int             n;
        bit             top;
        bit             quick;
        bit [32:0]      acc;
        bit [31:0]      step;
        bit [IP_W-1:0]  key;
        bit [CFG_W-1:0] f_val;
        bit [CFG_W-1:0] e_val;
        hit_t           none;

        pick = $urandom_range(0, 99);
        if (pick < 70)
            span = $urandom_range(1, 32);
        else if (pick < 95)
            span = $urandom_range(33, 160);
        else
            span = $urandom_range(161, 400);
        top       = ($urandom_range(0, 5) == 0);
        base_slot = top ? TBL - span : $urandom_range(0, TBL - span);
        quick     = ($urandom_range(0, 4) == 0);

        // mostly sorted spreads; some runs of near-duplicates, some unsorted
        mode = $urandom_range(0, 9);
        step = (mode == 1) ? 32'd3 : 32'hFFFF_FFFF / span;
        acc  = 33'($urandom_range(0, step));
        for (int i = 0; i < span; i++)
        begin
            hold_off(quick);
            issue(CMD_WRITE, EIDX_W'(base_slot + i), (mode == 0) ? $urandom : acc[31:0],
                  OFF_W'($urandom), 1'b0, none);
            acc = acc + 33'($urandom_range(0, step));
            if (acc[32])
                acc = 33'h0_FFFF_FFFF;
        end

        // bounds only ever cover entries that hold something
        settle();
        f_val = CFG_W'(base_slot);
        e_val = CFG_W'(base_slot + span);
        pick  = $urandom_range(0, 9);
        if (pick == 0)
        begin
            f_val = CFG_W'(base_slot + $urandom_range(0, span - 1));
            e_val = CFG_W'($urandom_range(0, f_val));
        end
        else if (pick == 1)
        begin
            f_val = CFG_W'($urandom_range(TBL, 2**CFG_W - 1));
            e_val = CFG_W'($urandom_range(0, 2**CFG_W - 1));
        end
        else if (pick == 2 && top)
            e_val = CFG_W'($urandom_range(TBL, 2**CFG_W - 1));
        else if (pick == 3)
            e_val = f_val;
        if ($urandom_range(0, 1))
        begin
            write_reg(CFG_IDX_FIRST_ENTRY, f_val);
            write_reg(CFG_IDX_END_ENTRY, e_val);
        end
        else
        begin
            write_reg(CFG_IDX_END_ENTRY, e_val);
            write_reg(CFG_IDX_FIRST_ENTRY, f_val);
        end

        n = $urandom_range(8, 40);
        for (int i = 0; i < n; i++)
        begin
            hold_off(quick);
            pick = $urandom_range(0, 99);
            if (pick < 10)
            begin
                // stray write into the window, may break the ordering
                issue(CMD_WRITE, EIDX_W'(base_slot + $urandom_range(0, span - 1)),
                      $urandom, OFF_W'($urandom), 1'b0, none);
            end
            else
            begin
                key = range_start[base_slot + $urandom_range(0, span - 1)];
                if (pick < 55)
                    key = key + $urandom_range(0, 4) - 2;
                else if (pick >= 70 && pick < 80)
                    key = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
                else if (pick >= 80)
                    key = $urandom;
                issue(CMD_LOOKUP, EIDX_W'($urandom), key, OFF_W'($urandom), 1'b0, none);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Result monitor and activity count for the watchdog. Results cannot be
    // held off, so every done cycle is checked against the oldest answer.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        hit_t h;
        if (!rst_n)
            quiet = 0;
        else
        begin
            if ((start && !busy) || done || cfg_we)
                quiet = 0;
            else
                quiet++;
            if (done)
            begin
                if (pending_hits.size() == 0)
                begin
                    $error("result with no lookup outstanding: found_index %0d",
                           found_index);
                    errors++;
                end
                else
                begin
                    h = pending_hits.pop_front();
                    n_checked++;
                    if (found_index !== h.idx)
                    begin
                        $error("found_index mismatch: expected %0d, got %0d",
                               h.idx, found_index);
                        errors++;
                    end
                    if (found_offset !== h.off)
                    begin
                        $error("found_offset mismatch: expected 0x%06h, got 0x%06h",
                               h.off, found_offset);
                        errors++;
                    end
                end
            end
        end
    end

    // Watchdog: a long stretch with no start taken, result or register write means a hang.
    initial
    begin
        while (quiet < QUIET_LIMIT)
            @(posedge clk);
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_IDX_FIRST_ENTRY;
        cfg_data      = '0;
        start         = 1'b0;
        cmd           = CMD_WRITE;
        entry_index   = '0;
        ip_value      = '0;
        record_offset = '0;
        first_reg     = '0;
        end_reg       = '0;
        errors        = 0;
        quiet         = 0;
        n_writes      = 0;
        n_lookups     = 0;
        n_checked     = 0;
        n_reg_writes  = 0;

        // Directed part. After reset both bounds are zero, so entry 0 answers
        // everything; then a four-entry table with extreme starts and
        // offsets, an inverted span, and bounds beyond the table at the top.
        directed_rows.push_back(wr_row(12'd0, 32'h1000_0000, 24'hAB_CDEF));
        directed_rows.push_back(lk_row(32'h0000_0000, 1'b1, 12'd0, 24'hAB_CDEF));
        directed_rows.push_back(lk_row(32'hFFFF_FFFF, 1'b1, 12'd0, 24'hAB_CDEF));
        directed_rows.push_back(wr_row(12'd1, 32'h2000_0000, 24'h00_0000));
        directed_rows.push_back(wr_row(12'd2, 32'h8000_0000, 24'h12_3456));
        directed_rows.push_back(wr_row(12'd3, 32'hFFFF_FFFF, 24'hFF_FFFF));
        directed_rows.push_back(reg_row(CFG_IDX_END_ENTRY, 13'd4));
        directed_rows.push_back(lk_row(32'h0000_0000, 1'b1, 12'd0, 24'hAB_CDEF));
        directed_rows.push_back(lk_row(32'hFFFF_FFFF, 1'b1, 12'd3, 24'hFF_FFFF));
        directed_rows.push_back(lk_row(32'h2000_0000, 1'b1, 12'd1, 24'h00_0000));
        directed_rows.push_back(lk_row(32'h7FFF_FFFF, 1'b0, 12'd0, 24'h0));
        directed_rows.push_back(lk_row(32'h8000_0000, 1'b1, 12'd2, 24'h12_3456));
        // inverted span: only the first entry is probed
        directed_rows.push_back(reg_row(CFG_IDX_FIRST_ENTRY, 13'd3));
        directed_rows.push_back(reg_row(CFG_IDX_END_ENTRY, 13'd1));
        directed_rows.push_back(lk_row(32'h0000_0000, 1'b1, 12'd3, 24'hFF_FFFF));
        // top of the table, first bound beyond it clamps to the last entry
        directed_rows.push_back(wr_row(12'd4095, 32'h0000_0001, 24'h5A_5A5A));
        directed_rows.push_back(wr_row(12'd4094, 32'h0000_0000, 24'h00_0001));
        directed_rows.push_back(reg_row(CFG_IDX_FIRST_ENTRY, 13'd8191));
        directed_rows.push_back(lk_row(32'h1234_5678, 1'b1, 12'd4095, 24'h5A_5A5A));
        // end bound beyond the table clamps to the table size
        directed_rows.push_back(reg_row(CFG_IDX_FIRST_ENTRY, 13'd4094));
        directed_rows.push_back(reg_row(CFG_IDX_END_ENTRY, 13'd8191));
        directed_rows.push_back(lk_row(32'h0000_0000, 1'b1, 12'd4094, 24'h00_0001));
        directed_rows.push_back(lk_row(32'hFFFF_FFFF, 1'b1, 12'd4095, 24'h5A_5A5A));
        directed_rows.push_back(lk_row(32'h0000_0001, 1'b0, 12'd0, 24'h0));
        directed_rows.push_back(reg_row(CFG_IDX_FIRST_ENTRY, 13'd4096));
        directed_rows.push_back(reg_row(CFG_IDX_END_ENTRY, 13'd0));
        directed_rows.push_back(lk_row(32'h0000_0000, 1'b1, 12'd4095, 24'h5A_5A5A));

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_reg)
            begin
                settle();
                write_reg(directed_rows[i].reg_sel, directed_rows[i].reg_val);
            end
            else
            begin
                hold_off(1'b0);
                issue(directed_rows[i].op, directed_rows[i].slot, directed_rows[i].ip,
                      directed_rows[i].off, directed_rows[i].typed, directed_rows[i].want);
            end
        end

        // Random phases; each one starts by draining the block completely.
        while (n_writes + n_lookups < ITEM_TARGET)
        begin
            settle();
            run_phase();
        end

        @(negedge clk);
        start = 1'b0;
        while (pending_hits.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (pending_hits.size() != 0)
        begin
            $error("%0d lookup results never arrived", pending_hits.size());
            errors++;
        end

        $display("covered %0d entry writes and %0d lookups, %0d results checked",
                 n_writes, n_lookups, n_checked);
        $display("%0d bound register writes, incl. empty, inverted and clamped spans",
                 n_reg_writes);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- files.f -----
src/iprtl_pkg.sv
src/iprtl_table.sv
src/iprtl_search.sv
src/ip_range_table_lookup.sv
tb/tb_top.sv
